// ===== rtl/core/u8250_pkg.sv =====
// ----------------------------------------------------------------------------
// u8250_pkg
// types, register offsets and flag positions shared by the 8250 register model
// ----------------------------------------------------------------------------
package u8250_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PULL  = 2'd2,
        OP_PUSH  = 2'd3
    } t_opcode;

    // register offsets
    localparam logic [2:0] ADDR_DATA  = 3'd0;
    localparam logic [2:0] ADDR_IER   = 3'd1;
    localparam logic [2:0] ADDR_IID   = 3'd2;
    localparam logic [2:0] ADDR_LCR   = 3'd3;
    localparam logic [2:0] ADDR_MCR   = 3'd4;
    localparam logic [2:0] ADDR_LSR   = 3'd5;
    localparam logic [2:0] ADDR_MSR   = 3'd6;
    localparam logic [2:0] ADDR_SPARE = 3'd7;

    // status flag bits
    localparam int SF_DR   = 0;
    localparam int SF_OE   = 1;
    localparam int SF_PE   = 2;
    localparam int SF_FE   = 3;
    localparam int SF_BRK  = 4;
    localparam int SF_THRE = 5;
    localparam int SF_TSE  = 6;
    localparam int SF_RSF  = 7;
    localparam logic [7:0] SF_RESET = 8'h60;

    // modem flag bits
    localparam int MF_DCTS = 0;
    localparam int MF_DDSR = 1;
    localparam int MF_TERI = 2;
    localparam int MF_DDCD = 3;
    localparam int MF_CTS  = 4;
    localparam int MF_DSR  = 5;
    localparam int MF_RI   = 6;
    localparam int MF_DCD  = 7;
    localparam int MF_PRI  = 8;

    localparam int LCR_BRK = 6;
    localparam int LCR_DLA = 7;
    localparam int MC_DTR  = 0;
    localparam int MC_RTS  = 1;
    localparam int MC_OUT1 = 2;
    localparam int MC_OUT2 = 3;
    localparam int MC_LOOP = 4;

    localparam logic [7:0] IID_NONE   = 8'h01;
    localparam logic [7:0] IID_RXDATA = 8'h06;
    localparam logic [7:0] IID_THRE   = 8'h04;
    localparam logic [7:0] IID_LINE   = 8'h02;
    localparam logic [7:0] IID_MODEM  = 8'h00;
    localparam logic [7:0] READ_UNUSED = 8'hFF;

    typedef struct packed {
        t_opcode     opcode;
        logic [2:0]  reg_address;
        logic [7:0]  write_data;
        logic        modem_valid;
        logic        dcd_pin;
        logic        dsr_pin;
        logic        cts_pin;
        logic        line_valid;
        logic [7:0]  rx_byte;
        logic [3:0]  rx_errors;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq;
        logic [7:0]  tx_char;
        logic [4:0]  pins;
        logic        device_changed;
    } t_result;

    typedef struct packed {
        logic [1:0]  count;
        logic        full;
    } t_qstat;

    function automatic logic irq_level(input logic [3:0] ier, input logic [7:0] sf,
                                       input logic [8:0] mf);
        irq_level = (ier[0] & sf[SF_DR]) | (ier[1] & sf[SF_THRE]) |
                    (ier[2] & (|sf[SF_BRK:SF_OE])) | (ier[3] & (|mf[MF_DDCD:MF_DCTS]));
    endfunction

    function automatic logic [7:0] iid_code(input logic [3:0] ier, input logic [7:0] sf,
                                            input logic [8:0] mf);
        if (!irq_level(ier, sf, mf)) begin
            iid_code = IID_NONE;
        end else if (ier[0] && sf[SF_DR]) begin
            iid_code = IID_RXDATA;
        end else if (ier[1] && sf[SF_THRE]) begin
            iid_code = IID_THRE;
        end else if (ier[2] && (|sf[SF_BRK:SF_OE])) begin
            iid_code = IID_LINE;
        end else begin
            iid_code = IID_MODEM;
        end
    endfunction

endpackage

// ===== rtl/core/u8250_core.sv =====
// ----------------------------------------------------------------------------
// u8250_core
// register file state and the single-pass update for one event item
// ----------------------------------------------------------------------------
module u8250_core import u8250_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic [7:0] r_dll, r_dlh, r_lcr, r_rbr, r_rsr, r_thr, r_tsr, r_sf, r_last_ch;
    logic [3:0] r_ier;
    logic [4:0] r_mcr, r_last_pins;
    logic [8:0] r_mf;

    logic [7:0] n_dll, n_dlh, n_lcr, n_rbr, n_rsr, n_thr, n_tsr, n_sf, n_last_ch;
    logic [3:0] n_ier;
    logic [4:0] n_mcr, n_last_pins;
    logic [8:0] n_mf;
    logic [7:0] rd;
    logic       changed;

    always_comb begin
        logic       loop;
        logic       dr;
        logic       rsf;
        logic       ri;
        logic       overrun;
        logic [7:0] d;
        loop    = r_mcr[MC_LOOP];
        dr      = r_sf[SF_DR];
        rsf     = r_sf[SF_RSF];
        d       = i_item.write_data;
        ri      = r_mcr[MC_OUT1];
        overrun = 1'b0;
        n_dll = r_dll;
        n_dlh = r_dlh;
        n_ier = r_ier;
        n_lcr = r_lcr;
        n_mcr = r_mcr;
        n_rbr = r_rbr;
        n_rsr = r_rsr;
        n_thr = r_thr;
        n_tsr = r_tsr;
        n_sf  = r_sf;
        n_mf  = r_mf;
        n_last_ch   = r_last_ch;
        n_last_pins = r_last_pins;
        rd      = 8'h00;
        changed = 1'b0;
        case (i_item.opcode)
            OP_WRITE: begin
                case (i_item.reg_address)
                    ADDR_DATA: begin
                        if (r_lcr[LCR_DLA]) begin
                            n_dll = d;
                        end else begin
                            n_thr = d;
                            if (r_lcr[LCR_BRK] || !(loop || r_sf[SF_TSE])) begin
                                n_sf[SF_THRE] = 1'b0;
                            end else begin
                                n_tsr = d;
                                if (loop) begin
                                    // loopback: byte goes straight into the receive path
                                    n_rsr = d;
                                    if (dr && rsf) begin
                                        n_sf[SF_OE] = 1'b1;
                                    end else if (!dr) begin
                                        n_rbr = d;
                                        n_sf[SF_RSF] = 1'b0;
                                    end else begin
                                        n_sf[SF_RSF] = 1'b1;
                                    end
                                    n_sf[SF_DR]   = 1'b1;
                                    n_sf[SF_TSE]  = 1'b1;
                                    n_sf[SF_THRE] = 1'b1;
                                end else begin
                                    n_sf[SF_THRE] = 1'b1;
                                    n_sf[SF_TSE]  = 1'b0;
                                end
                            end
                        end
                    end
                    ADDR_IER: begin
                        if (r_lcr[LCR_DLA]) begin
                            n_dlh = d;
                        end else begin
                            n_ier = d[3:0];
                        end
                    end
                    ADDR_LCR: begin
                        n_lcr = d;
                        if (loop) begin
                            n_sf[SF_BRK] = d[LCR_BRK];
                        end
                    end
                    ADDR_MCR: begin
                        n_mcr = d[4:0];
                        if (d[MC_LOOP]) begin
                            n_mf[MF_DCTS] = r_mf[MF_CTS] ^ d[MC_RTS];
                            n_mf[MF_DDSR] = r_mf[MF_DSR] ^ d[MC_DTR];
                            n_mf[MF_TERI] = r_mf[MF_RI] & ~d[MC_OUT1];
                            n_mf[MF_DDCD] = r_mf[MF_DCD] ^ d[MC_OUT2];
                            n_mf[MF_CTS]  = d[MC_RTS];
                            n_mf[MF_DSR]  = d[MC_DTR];
                            n_mf[MF_RI]   = d[MC_OUT1];
                            n_mf[MF_DCD]  = d[MC_OUT2];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_READ: begin
                case (i_item.reg_address)
                    ADDR_DATA: begin
                        if (r_lcr[LCR_DLA]) begin
                            rd = r_dll;
                        end else if (rsf) begin
                            // buffer empty with shift full hands out the shift byte
                            rd    = dr ? r_rbr : r_rsr;
                            n_rbr = r_rsr;
                            n_sf[SF_RSF] = 1'b0;
                        end else begin
                            rd = r_rbr;
                            n_sf[SF_DR] = 1'b0;
                        end
                    end
                    ADDR_IER: rd = r_lcr[LCR_DLA] ? r_dlh : {4'b0000, r_ier};
                    ADDR_IID: rd = iid_code(r_ier, r_sf, r_mf);
                    ADDR_LCR: rd = r_lcr;
                    ADDR_MCR: rd = {3'b000, r_mcr};
                    ADDR_LSR: begin
                        rd = {1'b0, r_sf[6:0]};
                        n_sf[SF_BRK:SF_OE] = 4'b0000;
                    end
                    ADDR_MSR: begin
                        rd = r_mf[7:0];
                        n_mf[MF_DDCD:MF_DCTS] = 4'b0000;
                    end
                    default: rd = READ_UNUSED;
                endcase
            end
            OP_PULL: begin
                if (loop) begin
                    n_last_pins = 5'b00000;
                end else begin
                    n_last_pins = {r_lcr[LCR_BRK], r_mcr[3:0]};
                    if (!r_sf[SF_TSE]) begin
                        n_last_ch = r_tsr;
                        n_sf[SF_TSE] = 1'b1;
                    end
                    // refill the emptied shift register from a pending holding byte
                    if (!r_lcr[LCR_BRK] && !r_sf[SF_THRE]) begin
                        n_tsr = r_thr;
                        n_sf[SF_THRE] = 1'b1;
                        n_sf[SF_TSE]  = 1'b0;
                    end
                end
                changed = (n_last_ch != r_last_ch) || (n_last_pins != r_last_pins);
            end
            OP_PUSH: begin
                if (!loop) begin
                    n_mf[MF_TERI] = r_mf[MF_PRI] & ~ri;
                    n_mf[MF_RI]   = ri;
                    n_mf[MF_PRI]  = ri;
                    if (i_item.modem_valid) begin
                        n_mf[MF_DDCD] = r_mf[MF_DCD] ^ i_item.dcd_pin;
                        n_mf[MF_DDSR] = r_mf[MF_DSR] ^ i_item.dsr_pin;
                        n_mf[MF_DCTS] = r_mf[MF_CTS] ^ i_item.cts_pin;
                        n_mf[MF_DCD]  = i_item.dcd_pin;
                        n_mf[MF_DSR]  = i_item.dsr_pin;
                        n_mf[MF_CTS]  = i_item.cts_pin;
                    end
                    if (i_item.line_valid) begin
                        // nul bytes are dropped but their error bits still count
                        if (i_item.rx_byte != 8'h00) begin
                            if (dr && rsf) begin
                                n_rsr   = i_item.rx_byte;
                                overrun = 1'b1;
                            end else if (rsf) begin
                                n_rbr = r_rsr;
                                n_rsr = i_item.rx_byte;
                                n_sf[SF_DR]  = 1'b1;
                                n_sf[SF_RSF] = 1'b1;
                            end else if (dr) begin
                                n_rsr = i_item.rx_byte;
                                n_sf[SF_RSF] = 1'b1;
                            end else begin
                                n_rbr = i_item.rx_byte;
                                n_sf[SF_DR]  = 1'b1;
                                n_sf[SF_RSF] = 1'b0;
                            end
                        end
                        n_sf[SF_FE]  = i_item.rx_errors[2];
                        n_sf[SF_PE]  = i_item.rx_errors[1];
                        n_sf[SF_BRK] = i_item.rx_errors[3];
                        n_sf[SF_OE]  = i_item.rx_errors[0] | overrun;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.read_data      = rd;
        o_result.irq            = irq_level(n_ier, n_sf, n_mf);
        o_result.tx_char        = n_last_ch;
        o_result.pins           = n_last_pins;
        o_result.device_changed = changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dll       <= 8'h00;
            r_dlh       <= 8'h00;
            r_ier       <= 4'h0;
            r_lcr       <= 8'h00;
            r_mcr       <= 5'h00;
            r_rbr       <= 8'h00;
            r_rsr       <= 8'h00;
            r_thr       <= 8'h00;
            r_tsr       <= 8'h00;
            r_sf        <= SF_RESET;
            r_mf        <= 9'h000;
            r_last_ch   <= 8'h00;
            r_last_pins <= 5'h00;
        end else if (i_fire) begin
            r_dll       <= n_dll;
            r_dlh       <= n_dlh;
            r_ier       <= n_ier;
            r_lcr       <= n_lcr;
            r_mcr       <= n_mcr;
            r_rbr       <= n_rbr;
            r_rsr       <= n_rsr;
            r_thr       <= n_thr;
            r_tsr       <= n_tsr;
            r_sf        <= n_sf;
            r_mf        <= n_mf;
            r_last_ch   <= n_last_ch;
            r_last_pins <= n_last_pins;
        end
    end

endmodule

// ===== rtl/core/u8250_outq.sv =====
// ----------------------------------------------------------------------------
// u8250_outq
// two-entry result queue that decouples the core from the output handshake
// ----------------------------------------------------------------------------
module u8250_outq import u8250_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_data,
    output t_qstat  o_stat
);

    t_result    r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = i_pop && (r_count != 2'd0);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/core/uart_8250_register_model.sv =====
// ----------------------------------------------------------------------------
// uart_8250_register_model
// 8250-style uart register file driven by bus and device event items
// ----------------------------------------------------------------------------
// channel  | handshake         | payload
// ---------+-------------------+-------------------------------------------
// event in | i_valid / o_ready | i_opcode .. i_rx_errors
// result   | o_valid / i_ready | o_read_data .. o_device_changed
//
// one item per cycle sustained while results are taken; an item's result is
// presented once it has passed the input register and the state update into
// the result queue. reset clears the core registers and occupancy counts,
// lsr flags come up with thre and tse set. o_ready decodes the registered item
// count: it drops once three items are held (input register plus two queue
// entries) and returns the cycle after a result is taken.
// ----------------------------------------------------------------------------
module uart_8250_register_model import u8250_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [2:0] i_reg_address,
    input  logic [7:0] i_write_data,
    input  logic       i_modem_valid,
    input  logic       i_dcd_pin,
    input  logic       i_dsr_pin,
    input  logic       i_cts_pin,
    input  logic       i_line_valid,
    input  logic [7:0] i_rx_byte,
    input  logic [3:0] i_rx_errors,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic       o_irq,
    output logic [7:0] o_tx_char,
    output logic       o_dtr_out,
    output logic       o_rts_out,
    output logic       o_out1_out,
    output logic       o_out2_out,
    output logic       o_break_out,
    output logic       o_device_changed
);

    t_item      r_s1_item;
    logic       r_s1_valid;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       in_acc;
    logic       out_acc;
    logic       advance;
    t_result    core_res;
    t_result    q_data;
    t_qstat     q_stat;

    assign o_ready = (r_count != 2'd3);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign advance = r_s1_valid && (!q_stat.full || out_acc);
    assign n_count = r_count + {1'b0, in_acc} - {1'b0, out_acc};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item.opcode      <= t_opcode'(i_opcode);
            r_s1_item.reg_address <= i_reg_address;
            r_s1_item.write_data  <= i_write_data;
            r_s1_item.modem_valid <= i_modem_valid;
            r_s1_item.dcd_pin     <= i_dcd_pin;
            r_s1_item.dsr_pin     <= i_dsr_pin;
            r_s1_item.cts_pin     <= i_cts_pin;
            r_s1_item.line_valid  <= i_line_valid;
            r_s1_item.rx_byte     <= i_rx_byte;
            r_s1_item.rx_errors   <= i_rx_errors;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_count    <= 2'd0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            r_count <= n_count;
        end
    end

    u8250_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_s1_item),
        .o_result (core_res)
    );

    u8250_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (core_res),
        .i_pop   (i_ready),
        .o_valid (o_valid),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    assign o_read_data      = q_data.read_data;
    assign o_irq            = q_data.irq;
    assign o_tx_char        = q_data.tx_char;
    assign o_dtr_out        = q_data.pins[0];
    assign o_rts_out        = q_data.pins[1];
    assign o_out1_out       = q_data.pins[2];
    assign o_out2_out       = q_data.pins[3];
    assign o_break_out      = q_data.pins[4];
    assign o_device_changed = q_data.device_changed;

`ifndef SYNTHESIS
    // occupancy bookkeeping matches the input register plus queue contents
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == ({1'b0, r_s1_valid} + q_stat.count))
        else $error("item count out of step with pipeline contents");

    // an accepted item is held in the input register next cycle
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted item not captured");

    // a held item with queue space always moves on, so the queue is non-empty after
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !q_stat.full) |=> (q_stat.count != 2'd0))
        else $error("held item did not reach the result queue");

    // never accept when input register and queue are both occupied, even if a result is taken
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && q_stat.full) |-> !o_ready)
        else $error("ready high with no room left");
`endif

endmodule
